/* rtl/mtx_pkg.sv */
// Package for the Mersenne-twister XOR stream cipher.
// Sizes, generator constants, register codes. No dependencies.
package mtx_pkg;

  localparam int STATE_WORDS   = 644;
  localparam int KEY_BYTES     = 32;
  localparam int TWIST_OFFSET  = 397;
  localparam int REG_KEY_BYTES = 32;
  localparam int KEY_WORDS     = REG_KEY_BYTES / 8;

  localparam int IDX_W     = $clog2(STATE_WORDS);
  localparam int KPOS_W    = $clog2(KEY_BYTES + 1);
  localparam int KIDX_W    = $clog2(REG_KEY_BYTES);
  localparam int SEED_W    = 30;
  localparam int KEY_LEN_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam logic [31:0] MATRIX_A   = 32'h9908_b0df;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [31:0] SEED_MULT  = 32'd1812433253;
  localparam logic [8:0]  MOD_BASE   = 9'd255;

  localparam logic [SEED_W-1:0]    SEED_RESET    = SEED_W'(5489);
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_HI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HI     = 3'd5;

endpackage

/* rtl/mtx_if.sv */
// Valid/ready channel interfaces for the cipher's input and output.
// Stand alone; no package needed.
interface mtx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface mtx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

/* rtl/mt_keystream_xor_cipher.sv */
// Byte stream cipher: Mersenne twister keystream mod 255 plus repeating short key.
// Uses mtx_pkg and the channel interfaces in mtx_if.sv.
//
// Each byte is XORed with a tempered twister word reduced mod 255 and with the
// next byte of a short repeating key. The transfer cycle (S_RD after a reseed)
// issues the two reads of the state RAM (one write port, two read ports); then
// S_GEN, once the output register is free, twists the current word, writes it
// back and loads the output register. The twist is done lazily, one word per
// byte, with the current word kept in a register. A restart (and the first byte
// after reset) reseeds the whole RAM first, each word through the registered
// multiplier (S_SEED_MUL, then S_SEED_ADD). Configuration writes apply at once;
// a new seed takes effect at the next restart.
module mt_keystream_xor_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mtx_in_if.sink                        in_ch,
  mtx_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [mtx_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mtx_pkg::CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_ADD,
    S_RD,
    S_GEN
  } state_e;

  localparam int N = mtx_pkg::STATE_WORDS;
  localparam int IW = mtx_pkg::IDX_W;

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & mtx_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtx_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // configuration registers
  logic [mtx_pkg::SEED_W-1:0]    seed_q;
  logic [mtx_pkg::KEY_LEN_W-1:0] key_len_q;
  logic [mtx_pkg::CFG_W-1:0]     key_q [mtx_pkg::KEY_WORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= mtx_pkg::SEED_RESET;
      key_len_q <= mtx_pkg::KEY_LEN_RESET;
      for (int w = 0; w < mtx_pkg::KEY_WORDS; w++) key_q[w] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mtx_pkg::REG_SEED:       seed_q    <= cfg_data_i[mtx_pkg::SEED_W-1:0];
        mtx_pkg::REG_KEY_LEN:    key_len_q <= cfg_data_i[mtx_pkg::KEY_LEN_W-1:0];
        mtx_pkg::REG_KEY_LO:     key_q[0]  <= cfg_data_i;
        mtx_pkg::REG_KEY_MID_LO: key_q[1]  <= cfg_data_i;
        mtx_pkg::REG_KEY_MID_HI: key_q[2]  <= cfg_data_i;
        mtx_pkg::REG_KEY_HI:     key_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and datapath registers
  state_e                    state_q;
  logic                      seeded_q;
  logic [IW-1:0]             idx_q;
  logic [IW-1:0]             j_q;
  logic [mtx_pkg::KPOS_W-1:0] kpos_q;
  logic [31:0]               cur_q;
  logic [31:0]               prev_q;
  logic [31:0]               prod_q;
  logic [7:0]                data_q;
  logic                      out_valid_q;
  logic [7:0]                out_byte_q;

  // state RAM
  logic [31:0] mem [N];
  logic [31:0] rd_a_q, rd_b_q;
  logic        mem_we, rd_en;
  logic [IW-1:0] mem_waddr, rd_a_addr, rd_b_addr;
  logic [31:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) begin
      rd_a_q <= mem[rd_a_addr];
      rd_b_q <= mem[rd_b_addr];
    end
  end

  logic in_xfer, gen_go, reseed;
  assign in_ch.ready = (state_q == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign reseed      = in_ch.restart || !seeded_q;
  assign gen_go      = (state_q == S_GEN) && (!out_valid_q || out_ch.ready);

  // read addresses: next word and the word TWIST_OFFSET ahead, both mod N
  logic [IW:0] off_sum;
  always_comb begin
    rd_a_addr = (idx_q == IW'(N - 1)) ? '0 : idx_q + IW'(1);
    off_sum   = {1'b0, idx_q} + (IW+1)'(mtx_pkg::TWIST_OFFSET);
    if (off_sum >= (IW+1)'(N)) off_sum = off_sum - (IW+1)'(N);
    rd_b_addr = off_sum[IW-1:0];
  end

  // twist of the current word, then temper and reduce mod 255
  logic [31:0] tw_y, tw_word, tempered;
  logic [9:0]  byte_sum;
  logic [8:0]  fold;
  logic [7:0]  ks;
  always_comb begin
    tw_y    = (cur_q & mtx_pkg::UPPER_MASK) | (rd_a_q & ~mtx_pkg::UPPER_MASK);
    tw_word = rd_b_q ^ (tw_y >> 1) ^ (tw_y[0] ? mtx_pkg::MATRIX_A : 32'h0);
    tempered = temper(tw_word);
    byte_sum = {2'b0, tempered[7:0]} + {2'b0, tempered[15:8]}
             + {2'b0, tempered[23:16]} + {2'b0, tempered[31:24]};
    fold = {1'b0, byte_sum[7:0]} + {7'b0, byte_sum[9:8]};
    ks   = (fold >= mtx_pkg::MOD_BASE) ? 8'(fold - mtx_pkg::MOD_BASE) : fold[7:0];
  end

  // seeding step: registered multiply, then add the word index
  logic [31:0] mul_src, prod_d, seed_word;
  assign mul_src   = prev_q ^ (prev_q >> 30);
  assign prod_d    = mtx_pkg::SEED_MULT * mul_src;
  assign seed_word = prod_q + 32'(j_q);

  // short key byte
  logic [7:0]                 key_arr [mtx_pkg::REG_KEY_BYTES];
  logic [mtx_pkg::KPOS_W-1:0] len_eff, kpos_cur, kpos_d;
  logic [7:0]                 kb;
  always_comb begin
    for (int b = 0; b < mtx_pkg::REG_KEY_BYTES; b++) key_arr[b] = key_q[b / 8][(b % 8) * 8 +: 8];
    if (key_len_q == '0) len_eff = mtx_pkg::KPOS_W'(1);
    else if (int'(key_len_q) > mtx_pkg::KEY_BYTES) len_eff = mtx_pkg::KPOS_W'(mtx_pkg::KEY_BYTES);
    else len_eff = mtx_pkg::KPOS_W'(key_len_q);
    kpos_cur = (kpos_q >= len_eff) ? '0 : kpos_q;
    kb = (int'(kpos_cur) < mtx_pkg::REG_KEY_BYTES) ?
         key_arr[mtx_pkg::KIDX_W'(kpos_cur)] : 8'h00;
    kpos_d = kpos_cur + mtx_pkg::KPOS_W'(1);
  end

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = tw_word;
    rd_en     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && reseed) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = 32'(seed_q);
        end else if (in_xfer) begin
          rd_en = 1'b1;
        end
      end
      S_SEED_ADD: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = seed_word;
      end
      S_RD:    rd_en  = 1'b1;
      S_GEN:   mem_we = gen_go;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seeded_q    <= 1'b0;
      idx_q       <= '0;
      j_q         <= '0;
      kpos_q      <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      prod_q      <= '0;
      data_q      <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
    end else begin
      if (gen_go) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            data_q <= in_ch.data_byte;
            if (reseed) begin
              seeded_q <= 1'b1;
              kpos_q   <= '0;
              prev_q   <= 32'(seed_q);
              cur_q    <= 32'(seed_q);
              j_q      <= IW'(1);
              state_q  <= S_SEED_MUL;
            end else begin
              state_q <= S_GEN;
            end
          end
        end
        S_SEED_MUL: begin
          prod_q  <= prod_d;
          state_q <= S_SEED_ADD;
        end
        S_SEED_ADD: begin
          prev_q <= seed_word;
          if (j_q == IW'(N - 1)) begin
            idx_q   <= '0;
            state_q <= S_RD;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_SEED_MUL;
          end
        end
        S_RD: state_q <= S_GEN;
        S_GEN: begin
          if (gen_go) begin
            cur_q       <= rd_a_q;
            idx_q       <= rd_a_addr;
            kpos_q      <= kpos_d;
            out_byte_q  <= data_q ^ ks ^ kb;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.out_byte = out_byte_q;

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && rd_en))
    else $error("state RAM read and write in the same cycle");

  a_kpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(kpos_q) <= mtx_pkg::KEY_BYTES)
    else $error("key position out of range");

  a_unseeded_seeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && !seeded_q) |=> (state_q == S_SEED_MUL))
    else $error("first byte after reset did not reseed");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ch.ready))
    else $error("result dropped without transfer");

  a_gen_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GEN && out_valid_q && !out_ch.ready) |=> (state_q == S_GEN))
    else $error("result overwritten while output stalled");
`endif

endmodule
